@@ hdl/bcd_ascii_adjust_unit_assert.svh @@
// Assertion macros for the decimal adjust unit.
`ifndef BCD_ASCII_ADJUST_UNIT_ASSERT_SVH
`define BCD_ASCII_ADJUST_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define BAA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define BAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BAA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BAA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/baa_pkg.sv @@
package baa_pkg;

   // Number of division and multiplication steps, one per bit of a byte.
   localparam int BAA_CELLS = 8;

   localparam logic [7:0] LIMIT_AF   = 8'h9F;
   localparam logic [7:0] LIMIT_NOAF = 8'h99;
   localparam logic [7:0] HIGH_ADJ   = 8'h60;
   localparam logic [7:0] LOW_ADJ    = 8'h06;
   localparam logic [7:0] LOW_MASK   = 8'h0F;
   localparam logic [7:0] ALL_ONES   = 8'hFF;
   localparam logic [3:0] DIGIT_MAX  = 4'd9;

   typedef enum logic [2:0] {
      OP_AAA = 3'd0,
      OP_AAS = 3'd1,
      OP_AAM = 3'd2,
      OP_AAD = 3'd3,
      OP_DAA = 3'd4,
      OP_DAS = 3'd5
   } baa_op_type;

   // One instruction travelling along the cell chain.
   typedef struct packed {
      baa_op_type op;
      logic [7:0] al;
      logic [7:0] ah;
      logic [7:0] base;
      logic       carry;
      logic       aux_carry;
      logic       zero;
      logic       sign;
      logic       parity;
      logic       overflow;
      logic [7:0] dvd;     // dividend bits still to be brought down
      logic [7:0] rem;     // partial remainder
      logic [7:0] quo;     // quotient bits so far
      logic [7:0] mcand;   // base, shifted left once per cell
      logic [7:0] mplier;  // AH, shifted right once per cell
      logic [7:0] acc;     // AH * base, accumulated modulo 256
   } baa_item_type;

   typedef struct packed {
      logic [7:0] al;
      logic [7:0] ah;
      logic       carry;
      logic       aux_carry;
      logic       zero;
      logic       sign;
      logic       parity;
      logic       overflow;
      logic       divide_error;
   } baa_result_type;

endpackage

@@ hdl/baa_cell.sv @@
module baa_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  baa_pkg::baa_item_type up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output baa_pkg::baa_item_type dn_data
);
   import baa_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   baa_item_type data_ff;
   baa_item_type data_in;
   logic [8:0]   trial;
   logic         fits;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // One restoring division step and one shift-and-add multiply step.
   always_comb begin
      data_in = up_data;
      trial   = {up_data.rem, up_data.dvd[7]};
      fits    = trial >= {1'b0, up_data.base};
      data_in.rem    = fits ? 8'(trial - {1'b0, up_data.base}) : trial[7:0];
      data_in.quo    = {up_data.quo[6:0], fits};
      data_in.dvd    = {up_data.dvd[6:0], 1'b0};
      data_in.acc    = up_data.acc + (up_data.mplier[0] ? up_data.mcand : 8'd0);
      data_in.mcand  = {up_data.mcand[6:0], 1'b0};
      data_in.mplier = {1'b0, up_data.mplier[7:1]};
   end

   always_comb begin
      if (up_valid && up_ready) begin
         valid_in = 1'b1;
      end else if (dn_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/baa_adjust.sv @@
module baa_adjust (
   input  baa_pkg::baa_item_type   item,
   output baa_pkg::baa_result_type res
);
   import baa_pkg::*;

   logic       sub;
   logic       low_adj;
   logic       high_adj;
   logic [7:0] limit;
   logic [7:0] low_sum;
   logic [7:0] dec_sum;
   logic [7:0] high_sum;
   logic       common;

   assign sub      = (item.op == OP_AAS) || (item.op == OP_DAS);
   assign low_adj  = (item.al[3:0] > DIGIT_MAX) || item.aux_carry;
   assign limit    = item.aux_carry ? LIMIT_AF : LIMIT_NOAF;
   assign high_adj = (item.al > limit) || item.carry;
   assign low_sum  = sub ? 8'(item.al - LOW_ADJ) : 8'(item.al + LOW_ADJ);
   assign dec_sum  = low_adj ? low_sum : item.al;
   assign high_sum = sub ? 8'(dec_sum - HIGH_ADJ) : 8'(dec_sum + HIGH_ADJ);

   always_comb begin
      res.al           = item.al;
      res.ah           = item.ah;
      res.carry        = item.carry;
      res.aux_carry    = item.aux_carry;
      res.zero         = item.zero;
      res.sign         = item.sign;
      res.parity       = item.parity;
      res.overflow     = item.overflow;
      res.divide_error = 1'b0;
      common           = 1'b0;
      unique case (item.op)
         OP_AAA, OP_AAS: begin
            res.al        = dec_sum & LOW_MASK;
            res.ah        = !low_adj ? item.ah :
                            (sub ? 8'(item.ah - 8'd1) : 8'(item.ah + 8'd1));
            res.carry     = low_adj;
            res.aux_carry = low_adj;
         end
         OP_AAM: begin
            if (item.base == 8'd0) begin
               res.zero         = 1'b1;
               res.sign         = 1'b0;
               res.parity       = 1'b1;
               res.carry        = 1'b0;
               res.aux_carry    = 1'b0;
               res.overflow     = 1'b0;
               res.divide_error = 1'b1;
            end else begin
               res.ah = item.quo;
               res.al = item.rem;
               common = 1'b1;
            end
         end
         OP_AAD: begin
            res.al = 8'(item.al + item.acc);
            res.ah = 8'd0;
            common = 1'b1;
         end
         OP_DAA, OP_DAS: begin
            res.al        = high_adj ? high_sum : dec_sum;
            res.aux_carry = low_adj;
            res.carry     = high_adj;
            common        = 1'b1;
         end
         default: begin
         end
      endcase
      if (common) begin
         res.zero   = (res.al & ALL_ONES) == 8'd0;
         res.sign   = res.al[7];
         res.parity = ~^res.al;
      end
   end

endmodule

@@ hdl/bcd_ascii_adjust_unit.sv @@
// Throughput: one instruction per cycle unless the result channel stalls;
// the eight-cell chain that forms the AAM quotient and the AAD product one
// bit per cell sets the depth.
// Reset: synchronous, active high; it empties the chain and the result
// register; the data registers themselves are not reset.
module bcd_ascii_adjust_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_al_in,
   input  logic [7:0] req_ah_in,
   input  logic [7:0] req_base,
   input  logic       req_carry_in,
   input  logic       req_aux_carry_in,
   input  logic       req_zero_in,
   input  logic       req_sign_in,
   input  logic       req_parity_in,
   input  logic       req_overflow_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_al_out,
   output logic [7:0] rsp_ah_out,
   output logic       rsp_carry_out,
   output logic       rsp_aux_carry_out,
   output logic       rsp_zero_out,
   output logic       rsp_sign_out,
   output logic       rsp_parity_out,
   output logic       rsp_overflow_out,
   output logic       rsp_divide_error
);
   import baa_pkg::*;

`include "bcd_ascii_adjust_unit_assert.svh"

   // Links between cells: link 0 is the input channel, link BAA_CELLS feeds
   // the final adjust logic and the result register.
   logic           link_valid [BAA_CELLS+1];
   logic           link_ready [BAA_CELLS+1];
   baa_item_type   link_data  [BAA_CELLS+1];
   baa_result_type adjusted;
   baa_result_type rsp_ff;
   baa_result_type rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // The instruction enters with the working fields primed: the dividend
   // is AL, the multiplier is AH and the multiplicand is the base.
   always_comb begin
      link_data[0].op        = baa_op_type'(req_operation);
      link_data[0].al        = req_al_in;
      link_data[0].ah        = req_ah_in;
      link_data[0].base      = req_base;
      link_data[0].carry     = req_carry_in;
      link_data[0].aux_carry = req_aux_carry_in;
      link_data[0].zero      = req_zero_in;
      link_data[0].sign      = req_sign_in;
      link_data[0].parity    = req_parity_in;
      link_data[0].overflow  = req_overflow_in;
      link_data[0].dvd       = req_al_in;
      link_data[0].rem       = 8'd0;
      link_data[0].quo       = 8'd0;
      link_data[0].mcand     = req_base;
      link_data[0].mplier    = req_ah_in;
      link_data[0].acc       = 8'd0;
   end

   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];

   // Each cell brings down one dividend bit and adds one partial product.
   // A cell takes a new instruction whenever it is empty or its own
   // instruction moves on, so the chain runs full without bubbles.
   for (genvar i = 0; i < BAA_CELLS; i++) begin : g_cell
      baa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_data  (link_data[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_data  (link_data[i+1])
      );
   end

   // Digit adjustment, selection of the quotient or product, and the flags.
   baa_adjust u_adjust (
      .item (link_data[BAA_CELLS]),
      .res  (adjusted)
   );

   // The result register parts the chain from the result channel; it takes
   // a new result in the same cycle as its old one is transferred.
   assign link_ready[BAA_CELLS] = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (link_valid[BAA_CELLS] && link_ready[BAA_CELLS]) begin
         rsp_in       = adjusted;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_al_out        = rsp_ff.al;
   assign rsp_ah_out        = rsp_ff.ah;
   assign rsp_carry_out     = rsp_ff.carry;
   assign rsp_aux_carry_out = rsp_ff.aux_carry;
   assign rsp_zero_out      = rsp_ff.zero;
   assign rsp_sign_out      = rsp_ff.sign;
   assign rsp_parity_out    = rsp_ff.parity;
   assign rsp_overflow_out  = rsp_ff.overflow;
   assign rsp_divide_error  = rsp_ff.divide_error;

   // At the end of the chain the division must be exact: the remainder is
   // below the base, and quotient times base plus remainder gives back AL.
   `BAA_ASSERT_IMPL(a_rem_below_base, clock, reset, link_valid[BAA_CELLS] && link_data[BAA_CELLS].base != 8'd0, link_data[BAA_CELLS].rem < link_data[BAA_CELLS].base)
   `BAA_ASSERT_IMPL(a_div_exact, clock, reset, link_valid[BAA_CELLS] && link_data[BAA_CELLS].base != 8'd0, 16'(16'(link_data[BAA_CELLS].quo) * 16'(link_data[BAA_CELLS].base) + 16'(link_data[BAA_CELLS].rem)) == 16'(link_data[BAA_CELLS].al))
   // A divide error reports the flags of a zero result and clears the rest.
   `BAA_ASSERT_IMPL(a_div_error_flags, clock, reset, rsp_valid && rsp_divide_error, rsp_zero_out && rsp_parity_out && !rsp_sign_out && !rsp_carry_out && !rsp_aux_carry_out && !rsp_overflow_out)
   // A result taken from the chain appears in the result register next cycle.
   `BAA_ASSERT_NEXT(a_result_loaded, clock, reset, link_valid[BAA_CELLS] && link_ready[BAA_CELLS], rsp_valid)

endmodule

@@ tb/bcd_ascii_adjust_unit_test.sv @@
module bcd_ascii_adjust_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import baa_pkg::*;

   // The drain wait at the end covers the depth of the block twice over.
   localparam int PIPE_DEPTH        = 9;
   localparam int DRAIN_CYCLES      = 2 * PIPE_DEPTH + 4;
   // The receiver holds off for this long so that the chain fills and the input stalls.
   localparam int LONG_HOLD_CYCLES  = 150;
   // The watchdog's limit on cycles with no transfer on either channel. It sits well above
   // the long hold, the longest idle burst and the reset.
   localparam int IDLE_LIMIT        = 2000;

   // One instruction as it is offered on the input channel.
   typedef struct packed {
      baa_op_type op;
      logic [7:0] al;
      logic [7:0] ah;
      logic [7:0] base;
      logic       carry;
      logic       aux_carry;
      logic       zero;
      logic       sign;
      logic       parity;
      logic       overflow;
   } instruction_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_operation;
   logic [7:0] req_al_in;
   logic [7:0] req_ah_in;
   logic [7:0] req_base;
   logic       req_carry_in;
   logic       req_aux_carry_in;
   logic       req_zero_in;
   logic       req_sign_in;
   logic       req_parity_in;
   logic       req_overflow_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_al_out;
   logic [7:0] rsp_ah_out;
   logic       rsp_carry_out;
   logic       rsp_aux_carry_out;
   logic       rsp_zero_out;
   logic       rsp_sign_out;
   logic       rsp_parity_out;
   logic       rsp_overflow_out;
   logic       rsp_divide_error;

   // These are the register states that are still owed by the block, oldest first.
   baa_result_type pending_adjust_results[$];

   int  mismatch_count     = 0;
   int  results_checked    = 0;
   int  divide_errors_seen = 0;
   int  op_seen[8];
   bit  sender_idling      = 1'b1;
   bit  sink_idling        = 1'b1;
   bit  long_hold_request  = 1'b0;

   bcd_ascii_adjust_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_al_in         (req_al_in),
      .req_ah_in         (req_ah_in),
      .req_base          (req_base),
      .req_carry_in      (req_carry_in),
      .req_aux_carry_in  (req_aux_carry_in),
      .req_zero_in       (req_zero_in),
      .req_sign_in       (req_sign_in),
      .req_parity_in     (req_parity_in),
      .req_overflow_in   (req_overflow_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_al_out        (rsp_al_out),
      .rsp_ah_out        (rsp_ah_out),
      .rsp_carry_out     (rsp_carry_out),
      .rsp_aux_carry_out (rsp_aux_carry_out),
      .rsp_zero_out      (rsp_zero_out),
      .rsp_sign_out      (rsp_sign_out),
      .rsp_parity_out    (rsp_parity_out),
      .rsp_overflow_out  (rsp_overflow_out),
      .rsp_divide_error  (rsp_divide_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // This works out the state of AL, AH and the flags after one instruction. ZF, SF and PF
   // are rebuilt from the final AL only where the instruction writes the common flags.
   // Every other flag that the instruction leaves alone passes straight through.
   function automatic baa_result_type compute_adjusted_state(instruction_type ins);
      baa_result_type r;
      logic [7:0]     limit;
      logic           flags_from_al;
      r.al           = ins.al;
      r.ah           = ins.ah;
      r.carry        = ins.carry;
      r.aux_carry    = ins.aux_carry;
      r.zero         = ins.zero;
      r.sign         = ins.sign;
      r.parity       = ins.parity;
      r.overflow     = ins.overflow;
      r.divide_error = 1'b0;
      flags_from_al  = 1'b0;
      case (ins.op)
         OP_AAA, OP_AAS: begin
            if (ins.al[3:0] > DIGIT_MAX || ins.aux_carry) begin
               r.al        = (ins.op == OP_AAA) ? ins.al + LOW_ADJ : ins.al - LOW_ADJ;
               r.ah        = (ins.op == OP_AAA) ? ins.ah + 8'd1 : ins.ah - 8'd1;
               r.aux_carry = 1'b1;
               r.carry     = 1'b1;
            end else begin
               r.aux_carry = 1'b0;
               r.carry     = 1'b0;
            end
            r.al = r.al & LOW_MASK;
         end
         OP_AAM: begin
            // A zero base leaves AX alone and reports flags as for a zero result.
            if (ins.base == 8'd0) begin
               r.zero         = 1'b1;
               r.sign         = 1'b0;
               r.parity       = 1'b1;
               r.carry        = 1'b0;
               r.aux_carry    = 1'b0;
               r.overflow     = 1'b0;
               r.divide_error = 1'b1;
            end else begin
               r.ah          = ins.al / ins.base;
               r.al          = ins.al % ins.base;
               flags_from_al = 1'b1;
            end
         end
         OP_AAD: begin
            // The sum is formed at eight bits, so it wraps modulo 256 of its own accord.
            r.al          = ins.al + ins.ah * ins.base;
            r.ah          = 8'd0;
            flags_from_al = 1'b1;
         end
         OP_DAA, OP_DAS: begin
            // The high-digit limit is compared with AL as it was on entry.
            limit = ins.aux_carry ? LIMIT_AF : LIMIT_NOAF;
            if (ins.al[3:0] > DIGIT_MAX || ins.aux_carry) begin
               r.al        = (ins.op == OP_DAA) ? r.al + LOW_ADJ : r.al - LOW_ADJ;
               r.aux_carry = 1'b1;
            end else begin
               r.aux_carry = 1'b0;
            end
            if (ins.al > limit || ins.carry) begin
               r.al    = (ins.op == OP_DAA) ? r.al + HIGH_ADJ : r.al - HIGH_ADJ;
               r.carry = 1'b1;
            end else begin
               r.carry = 1'b0;
            end
            flags_from_al = 1'b1;
         end
         default: begin
         end
      endcase
      if (flags_from_al) begin
         r.zero   = (r.al == 8'd0);
         r.sign   = r.al[7];
         r.parity = ~^r.al;
      end
      return r;
   endfunction

   // The flags are packed as {OF, PF, SF, ZF, AF, CF} to keep the directed list short.
   function automatic instruction_type make_instruction(baa_op_type op, logic [7:0] al,
                                                        logic [7:0] ah, logic [7:0] base,
                                                        logic [5:0] flags);
      instruction_type ins;
      ins.op        = op;
      ins.al        = al;
      ins.ah        = ah;
      ins.base      = base;
      ins.overflow  = flags[5];
      ins.parity    = flags[4];
      ins.sign      = flags[3];
      ins.zero      = flags[2];
      ins.aux_carry = flags[1];
      ins.carry     = flags[0];
      return ins;
   endfunction

   // Random instructions lean towards the interesting corners: a low digit close to the
   // nine/ten boundary, a base of ten or zero, and AL near the DAA and DAS limits.
   function automatic instruction_type random_instruction();
      instruction_type ins;
      ins = make_instruction(baa_op_type'(3'($urandom_range(0, 5))), 8'($urandom),
                             8'($urandom), 8'($urandom), 6'($urandom));
      case ($urandom_range(0, 3))
         0: ins.al[3:0] = 4'($urandom_range(8, 11));
         1: ins.al = 8'($urandom_range(8'h96, 8'hA2));
         default: begin
         end
      endcase
      case ($urandom_range(0, 9))
         0:       ins.base = 8'd0;
         1, 2, 3: ins.base = 8'd10;
         default: begin
         end
      endcase
      return ins;
   endfunction

   // This offers one instruction from a falling edge and returns at the falling edge after
   // the transfer. When the sender is idling it may then drop valid for a random burst.
   task automatic send_instruction(instruction_type ins);
      req_valid        <= 1'b1;
      req_operation    <= ins.op;
      req_al_in        <= ins.al;
      req_ah_in        <= ins.ah;
      req_base         <= ins.base;
      req_carry_in     <= ins.carry;
      req_aux_carry_in <= ins.aux_carry;
      req_zero_in      <= ins.zero;
      req_sign_in      <= ins.sign;
      req_parity_in    <= ins.parity;
      req_overflow_in  <= ins.overflow;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   // The sender stops and waits until every result it is owed has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_adjust_results.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(string field_name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_flag(string field_name, logic want, logic got);
      if (want !== got) begin
         $error("%s: expected %0b, got %0b", field_name, want, got);
         mismatch_count++;
      end
   endtask

   // Each instruction is run with its boundary values: the low-digit limit, AF forcing
   // the adjustment, wrap-around of AL and AH, a zero base for AAM and AAD, the two DAA and
   // DAS limits, and the pass-through of the flags that the instruction does not write.
   task automatic test_directed_cases();
      send_instruction(make_instruction(OP_AAA, 8'h09, 8'h00, 8'h00, 6'b000000));
      send_instruction(make_instruction(OP_AAA, 8'h0A, 8'hFF, 8'h00, 6'b111100));
      send_instruction(make_instruction(OP_AAA, 8'hFF, 8'h12, 8'hFF, 6'b010101));
      send_instruction(make_instruction(OP_AAA, 8'h03, 8'h00, 8'h00, 6'b000010));
      send_instruction(make_instruction(OP_AAS, 8'h00, 8'h00, 8'h00, 6'b000010));
      send_instruction(make_instruction(OP_AAS, 8'h0B, 8'h05, 8'h0A, 6'b111101));
      send_instruction(make_instruction(OP_AAS, 8'h99, 8'h80, 8'h00, 6'b000000));
      send_instruction(make_instruction(OP_AAM, 8'hFF, 8'h00, 8'h0A, 6'b000000));
      send_instruction(make_instruction(OP_AAM, 8'h37, 8'h9C, 8'h00, 6'b111111));
      send_instruction(make_instruction(OP_AAM, 8'h00, 8'hFF, 8'h01, 6'b101011));
      send_instruction(make_instruction(OP_AAM, 8'hFF, 8'h00, 8'hFF, 6'b000000));
      send_instruction(make_instruction(OP_AAM, 8'h80, 8'h55, 8'h01, 6'b100011));
      send_instruction(make_instruction(OP_AAD, 8'hFF, 8'hFF, 8'hFF, 6'b000000));
      send_instruction(make_instruction(OP_AAD, 8'h05, 8'h07, 8'h00, 6'b100011));
      send_instruction(make_instruction(OP_AAD, 8'h00, 8'h00, 8'h0A, 6'b111111));
      send_instruction(make_instruction(OP_DAA, 8'h9A, 8'h00, 8'h00, 6'b000000));
      send_instruction(make_instruction(OP_DAA, 8'h9F, 8'h00, 8'h00, 6'b000010));
      send_instruction(make_instruction(OP_DAA, 8'hA0, 8'hFF, 8'h00, 6'b100010));
      send_instruction(make_instruction(OP_DAA, 8'h99, 8'h00, 8'h00, 6'b000001));
      send_instruction(make_instruction(OP_DAA, 8'h00, 8'h00, 8'h00, 6'b000000));
      send_instruction(make_instruction(OP_DAS, 8'h00, 8'h00, 8'h00, 6'b000011));
      send_instruction(make_instruction(OP_DAS, 8'h9A, 8'h00, 8'h00, 6'b000000));
      send_instruction(make_instruction(OP_DAS, 8'hFA, 8'hFF, 8'hFF, 6'b111111));
      send_instruction(make_instruction(OP_DAS, 8'h45, 8'h00, 8'h00, 6'b000000));
   endtask

   // Random instructions go in six chunks. Idling on each side is switched per chunk so
   // that some stretches run with no gaps at all.
   task automatic test_random_mix();
      for (int chunk = 0; chunk < 6; chunk++) begin
         sender_idling = (chunk % 2 == 0);
         sink_idling   = (chunk % 3 != 1);
         for (int n = 0; n < 50; n++) send_instruction(random_instruction());
      end
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering. The chain
   // fills up and the input has to stall until the results start to drain.
   task automatic test_back_pressure();
      sender_idling     = 1'b0;
      sink_idling       = 1'b0;
      long_hold_request = 1'b1;
      for (int n = 0; n < 40; n++) send_instruction(random_instruction());
      wait_for_results();
   endtask

   // The last part runs at one transfer per cycle on both sides with no idling.
   task automatic test_full_rate();
      sender_idling = 1'b0;
      sink_idling   = 1'b0;
      for (int n = 0; n < 100; n++) send_instruction(random_instruction());
   endtask

   // The receiver: random stall bursts while idling, and a long hold when one is asked for.
   // The hold is counted here so that it runs on its own while the sender keeps going.
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            rsp_ready <= 1'b0;
            for (int hold = 0; hold < LONG_HOLD_CYCLES; hold++) @(negedge clock);
            long_hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (sink_idling && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // At each rising edge a result transfer is checked against the oldest expectation, and
   // then an input transfer adds its own expectation at the back of the queue.
   always @(posedge clock) begin : scoreboard
      baa_result_type want;
      instruction_type ins;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_adjust_results.size() == 0) begin
               $error("result transfer with no instruction outstanding");
               mismatch_count++;
            end else begin
               want = pending_adjust_results.pop_front();
               check_field("al_out", want.al, rsp_al_out);
               check_field("ah_out", want.ah, rsp_ah_out);
               check_flag("carry_out", want.carry, rsp_carry_out);
               check_flag("aux_carry_out", want.aux_carry, rsp_aux_carry_out);
               check_flag("zero_out", want.zero, rsp_zero_out);
               check_flag("sign_out", want.sign, rsp_sign_out);
               check_flag("parity_out", want.parity, rsp_parity_out);
               check_flag("overflow_out", want.overflow, rsp_overflow_out);
               check_flag("divide_error", want.divide_error, rsp_divide_error);
               results_checked++;
               if (rsp_divide_error === 1'b1) divide_errors_seen++;
            end
         end
         if (req_valid && req_ready) begin
            ins = make_instruction(baa_op_type'(req_operation), req_al_in, req_ah_in,
                                   req_base, {req_overflow_in, req_parity_in, req_sign_in,
                                              req_zero_in, req_aux_carry_in, req_carry_in});
            pending_adjust_results.push_back(compute_adjusted_state(ins));
            op_seen[req_operation]++;
         end
      end
   end

   // The watchdog ends the run when neither channel has made a transfer for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $error("no transfer for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_AAA;
      req_al_in        = 8'd0;
      req_ah_in        = 8'd0;
      req_base         = 8'd0;
      req_carry_in     = 1'b0;
      req_aux_carry_in = 1'b0;
      req_zero_in      = 1'b0;
      req_sign_in      = 1'b0;
      req_parity_in    = 1'b0;
      req_overflow_in  = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      wait_for_results();
      test_random_mix();
      test_back_pressure();
      test_full_rate();

      req_valid <= 1'b0;
      while (pending_adjust_results.size() != 0) @(posedge clock);
      // The drain wait shows up any stray result that was never asked for.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d results: AAA %0d, AAS %0d, AAM %0d, AAD %0d, DAA %0d, DAS %0d.",
               results_checked, op_seen[OP_AAA], op_seen[OP_AAS], op_seen[OP_AAM],
               op_seen[OP_AAD], op_seen[OP_DAA], op_seen[OP_DAS]);
      $display("Included %0d zero-base divide errors, a long receiver stall and a full-rate run.",
               divide_errors_seen);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
